// ----- design/hrpc_pkg.sv -----
// Package for the heading-rate PI controller: fixed-point constants, register
// indexes and the widths of the shared multiplier.
// No dependencies.
`default_nettype none

package hrpc_pkg;

  // Angle constants in Q4.12.
  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic signed [31:0] ONE_Q12    = 32'sd4096;

  // Rate limit is applied only above 0.01 rad/s (Q4.12).
  localparam logic [14:0] RATE_LIMIT_MIN = 15'd40;
  // Integrator runs only above 1 m/s (Q8.8).
  localparam logic [15:0] MIN_SPEED_Q8   = 16'd256;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TC    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIM  = 3'd5;

  // Shared multiplier: signed A by unsigned B, registered product.
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = 50;

endpackage

`default_nettype wire

// ----- design/hrpc_mul.sv -----
// Shared multiplier of the heading-rate controller: signed by unsigned with a
// registered product. Depends on hrpc_pkg.
`default_nettype none

module hrpc_mul (
  input  wire logic                               clk,
  input  wire logic signed [hrpc_pkg::MUL_A_W-1:0] a,
  input  wire logic        [hrpc_pkg::MUL_B_W-1:0] b,
  output logic      signed [hrpc_pkg::MUL_P_W-1:0] p
);
  import hrpc_pkg::*;

  logic signed [MUL_A_W+MUL_B_W:0] prod_full;

  // B is zero-extended so the product keeps A's sign.
  assign prod_full = a * $signed({1'b0, b});

  // The operands used here never produce a value beyond the product width.
  always_ff @(posedge clk) begin
    p <= prod_full[MUL_P_W-1:0];
  end

endmodule

`default_nettype wire

// ----- design/heading_rate_pi_controller_top.sv -----
// Top level of the heading-rate PI controller: outer heading loop, inner PI
// rate loop with feed-forward and anti-windup. Depends on hrpc_pkg, hrpc_mul.
//
//  Channel   Direction  Signals                                   Beat
//  s_axis    in         tvalid tready tdata[95:0] tuser[1:0]      one control tick
//  m_axis    out        tvalid tready tdata[31:0]                 one result
//  cfg       in         cfg_valid cfg_ready cfg_index cfg_data    one register write
//
// A tick is worked through one shared 34x16 multiplier stepped by a
// sequencer: the wrap step repeats until the heading error is in range, and
// the rate-loop steps run when the rate loop is enabled.
// s_axis_tready is high only while the sequencer is idle. A result that is
// not taken holds the sequencer in its last step. Reset is synchronous and
// restores the register defaults and clears the controller state.
`default_nettype none

module heading_rate_pi_controller_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input tick
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: heading_target, heading_measured, yaw_rate_measured,
  //        ground_speed, speed_scaler, step_time (16 bits each, low first)
  input  wire logic [95:0]                       s_axis_tdata,
  // tuser: heading_valid, rate_valid (low first)
  input  wire logic [1:0]                        s_axis_tuser,
  // Result
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: rate_setpoint[15:0], actuator_command[29:16], zero fill [31:30]
  output logic [31:0]                            m_axis_tdata,
  // Configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hrpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [15:0]                       cfg_data
);
  import hrpc_pkg::*;

  // Sequencer codes.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WRAP  = 4'd1;
  localparam logic [3:0] ST_HEAD  = 4'd2;
  localparam logic [3:0] ST_ERR   = 4'd3;
  localparam logic [3:0] ST_DT    = 4'd4;
  localparam logic [3:0] ST_DIFF  = 4'd5;
  localparam logic [3:0] ST_INTEG = 4'd6;
  localparam logic [3:0] ST_PROP  = 4'd7;
  localparam logic [3:0] ST_SPLIT = 4'd8;
  localparam logic [3:0] ST_LOW   = 4'd9;
  localparam logic [3:0] ST_FF    = 4'd10;
  localparam logic [3:0] ST_FFS   = 4'd11;
  localparam logic [3:0] ST_ACC   = 4'd12;
  localparam logic [3:0] ST_NORM  = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;

  // Configuration registers.
  logic [15:0] gain_p;
  logic [15:0] gain_i;
  logic [15:0] gain_ff;
  logic [14:0] int_limit;
  logic [15:0] inv_tc;
  logic [14:0] rate_limit;

  // Controller state.
  logic signed [15:0] held;
  logic signed [31:0] integ;
  logic signed [31:0] unclamped;

  // Captured tick fields and scratch registers.
  logic signed [17:0] wrap_r;
  logic signed [15:0] body_rate;
  logic        [15:0] speed;
  logic        [15:0] scaler;
  logic        [15:0] dt;
  logic               rate_ok;
  logic        [23:0] t_lo;
  logic signed [63:0] acc;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic        [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  hrpc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  logic in_beat;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Configuration register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p     <= 16'd256;
      gain_i     <= 16'd0;
      gain_ff    <= 16'd0;
      int_limit  <= 15'd1229;
      inv_tc     <= 16'd256;
      rate_limit <= 15'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_P:    gain_p     <= cfg_data;
        REG_GAIN_I:    gain_i     <= cfg_data;
        REG_GAIN_FF:   gain_ff    <= cfg_data;
        REG_INT_LIMIT: int_limit  <= cfg_data[14:0];
        REG_INV_TC:    inv_tc     <= cfg_data;
        REG_RATE_LIM:  rate_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Rate error and integrator gate.
  logic signed [16:0] rate_err;
  logic               integ_gate;
  assign rate_err   = {held[15], held} - {body_rate[15], body_rate};
  assign integ_gate = (gain_i != 16'd0) && (speed > MIN_SPEED_Q8);

  // Heading wrap tests and the wrapped error.
  logic               wrap_hi;
  logic               wrap_lo;
  logic signed [17:0] head_err;
  assign wrap_hi  = (wrap_r >= TWO_PI_Q12);
  assign wrap_lo  = (wrap_r < 18'sd0);
  assign head_err = wrap_r - PI_Q12;

  // Heading rate: round, saturate to 16 bits, apply the optional limit.
  logic signed [MUL_P_W-1:0] head_sh;
  logic signed [15:0]        head_sat;
  logic signed [15:0]        head_lim;
  logic signed [15:0]        lim_pos;
  always_comb begin
    head_sh = (mul_p + 50'sd128) >>> 8;
    if (head_sh > 50'sd32767) begin
      head_sat = 16'sd32767;
    end else if (head_sh < -50'sd32768) begin
      head_sat = -16'sd32768;
    end else begin
      head_sat = head_sh[15:0];
    end
    lim_pos  = $signed({1'b0, rate_limit});
    head_lim = head_sat;
    if (rate_limit > RATE_LIMIT_MIN) begin
      if (head_sat > lim_pos) begin
        head_lim = lim_pos;
      end else if (head_sat < -lim_pos) begin
        head_lim = -lim_pos;
      end
    end
  end

  // Integrator increment with anti-windup on the last unclamped output.
  logic signed [MUL_P_W-1:0] d_sh;
  logic signed [MUL_A_W-1:0] d_aw;
  always_comb begin
    d_sh = (mul_p + 50'sd32768) >>> 16;
    d_aw = d_sh[MUL_A_W-1:0];
    if ((unclamped < -ONE_Q12) && (d_aw < 34'sd0)) begin
      d_aw = '0;
    end else if ((unclamped > ONE_Q12) && (d_aw > 34'sd0)) begin
      d_aw = '0;
    end
  end

  // Integrator sum and symmetric clamp.
  logic signed [MUL_P_W-1:0] inc_sh;
  logic signed [MUL_P_W-1:0] integ_sum;
  logic signed [MUL_P_W-1:0] ilim;
  logic signed [31:0]        integ_new;
  always_comb begin
    inc_sh    = (mul_p + 50'sd128) >>> 8;
    integ_sum = {{(MUL_P_W-32){integ[31]}}, integ} + inc_sh;
    ilim      = $signed({{(MUL_P_W-27){1'b0}}, int_limit, 12'd0});
    if (integ_sum > ilim) begin
      integ_new = ilim[31:0];
    end else if (integ_sum < -ilim) begin
      integ_new = -ilim[31:0];
    end else begin
      integ_new = integ_sum[31:0];
    end
  end

  // Proportional plus integral term, before speed scaling.
  logic signed [MUL_P_W-1:0] p_sh;
  logic signed [32:0]        i_sh;
  logic signed [MUL_A_W-1:0] pi_sum;
  always_comb begin
    p_sh   = (mul_p + 50'sd8) >>> 4;
    i_sh   = ($signed({integ[31], integ}) + 33'sd128) >>> 8;
    pi_sum = p_sh[MUL_A_W-1:0] + {i_sh[32], i_sh};
  end

  // Final rounding to Q.12 and saturation to 32 bits.
  logic signed [63:0] out_sh;
  logic signed [31:0] out_sat;
  always_comb begin
    out_sh = (acc + 64'sd134217728) >>> 28;
    if (out_sh > 64'sd2147483647) begin
      out_sat = 32'sh7FFFFFFF;
    end else if (out_sh < -64'sd2147483648) begin
      out_sat = 32'sh80000000;
    end else begin
      out_sat = out_sh[31:0];
    end
  end

  // Actuator clamp to plus or minus one.
  logic signed [13:0] act;
  always_comb begin
    if (unclamped > ONE_Q12) begin
      act = 14'sd4096;
    end else if (unclamped < -ONE_Q12) begin
      act = -14'sd4096;
    end else begin
      act = unclamped[13:0];
    end
  end

  // Sequencer: next step and multiplier operands.
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          if (s_axis_tuser[0]) begin
            state_next = ST_WRAP;
          end else if (s_axis_tuser[1]) begin
            state_next = ST_ERR;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_WRAP: begin
        mul_a = {{(MUL_A_W-18){head_err[17]}}, head_err};
        mul_b = inv_tc;
        if (!wrap_hi && !wrap_lo) begin
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        state_next = rate_ok ? ST_ERR : ST_OUT;
      end
      ST_ERR: begin
        mul_a = {{(MUL_A_W-17){rate_err[16]}}, rate_err};
        if (integ_gate) begin
          mul_b      = dt;
          state_next = ST_DT;
        end else begin
          mul_b      = gain_p;
          state_next = ST_PROP;
        end
      end
      ST_DT: begin
        mul_a      = mul_p[MUL_A_W-1:0];
        mul_b      = scaler;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        mul_a      = d_aw;
        mul_b      = gain_i;
        state_next = ST_INTEG;
      end
      ST_INTEG: begin
        mul_a      = {{(MUL_A_W-17){rate_err[16]}}, rate_err};
        mul_b      = gain_p;
        state_next = ST_PROP;
      end
      ST_PROP: begin
        mul_a      = pi_sum;
        mul_b      = scaler;
        state_next = ST_SPLIT;
      end
      ST_SPLIT: begin
        // Upper part of the once-scaled term; the lower 24 bits follow.
        mul_a      = {{(MUL_A_W-26){mul_p[MUL_P_W-1]}}, mul_p[MUL_P_W-1:24]};
        mul_b      = scaler;
        state_next = ST_LOW;
      end
      ST_LOW: begin
        mul_a      = {{(MUL_A_W-24){1'b0}}, t_lo};
        mul_b      = scaler;
        state_next = ST_FF;
      end
      ST_FF: begin
        mul_a      = {{(MUL_A_W-16){held[15]}}, held};
        mul_b      = gain_ff;
        state_next = ST_FFS;
      end
      ST_FFS: begin
        mul_a      = mul_p[MUL_A_W-1:0];
        mul_b      = scaler;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = ST_NORM;
      end
      ST_NORM: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      held          <= '0;
      integ         <= '0;
      unclamped     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // A beat taken outside the last step leaves the output empty.
      if (m_axis_tvalid && m_axis_tready && (state != ST_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_HEAD:  held      <= head_lim;
        ST_INTEG: integ     <= integ_new;
        ST_NORM:  unclamped <= out_sat;
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers: captured fields, wrap, accumulator, result.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      wrap_r    <= {{2{s_axis_tdata[15]}}, s_axis_tdata[15:0]}
                 - {{2{s_axis_tdata[31]}}, s_axis_tdata[31:16]} + PI_Q12;
      body_rate <= s_axis_tdata[47:32];
      speed     <= s_axis_tdata[63:48];
      scaler    <= s_axis_tdata[79:64];
      dt        <= s_axis_tdata[95:80];
      rate_ok   <= s_axis_tuser[1];
    end
    case (state)
      ST_WRAP: begin
        if (wrap_hi) begin
          wrap_r <= wrap_r - TWO_PI_Q12;
        end else if (wrap_lo) begin
          wrap_r <= wrap_r + TWO_PI_Q12;
        end
      end
      ST_SPLIT: t_lo <= mul_p[23:0];
      ST_LOW:   acc  <= {mul_p[39:0], 24'd0};
      ST_FF:    acc  <= acc + {{(64-MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p};
      ST_ACC:   acc  <= acc + {{(56-MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p, 8'd0};
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= {2'b00, act, held};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
